@@ rtl/srpg_pkg.sv @@
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types and codes for the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

   // request kinds carried in tuser
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // motion phase reported with each result
   typedef enum logic [1:0] {
      PH_STOP   = 2'd0,
      PH_ACCEL  = 2'd1,
      PH_CRUISE = 2'd2,
      PH_DECEL  = 2'd3
   } phase_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;     // latch the accepted request
      logic commit;      // update move state and load the result register
      logic div_setup;   // form operands and start the divider
      logic div_finish;  // apply signs, saturate and store the new interval
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_div;    // the step being committed updates the interval by division
      logic div_done;    // divider finishes at this edge
   } sts_type;

endpackage

@@ rtl/srpg_div.sv @@
// ----------------------------------------------------------------------------
// srpg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srpg_div #(
   parameter int MAG_BITS = 27
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MAG_BITS-1:0] dividend,
   input  logic [MAG_BITS-1:0] divisor,
   output logic [MAG_BITS-1:0] quotient,
   output logic [MAG_BITS-1:0] remainder,
   output logic                done
);

   localparam int CntW = $clog2(MAG_BITS + 1);

   logic                busy_ff;
   logic [CntW-1:0]     count_ff;
   logic [MAG_BITS-1:0] quo_ff;
   logic [MAG_BITS-1:0] rem_ff;
   logic [MAG_BITS-1:0] dvs_ff;
   logic [MAG_BITS:0]   shifted;
   logic [MAG_BITS:0]   diff;

   // trial subtraction of the divisor from the shifted partial remainder
   assign shifted = {rem_ff, quo_ff[MAG_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   assign done      = busy_ff && (count_ff == CntW'(1));
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CntW'(MAG_BITS);
      end else if (busy_ff) begin
         count_ff <= count_ff - CntW'(1);
         if (count_ff == CntW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // operand and partial result registers
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[MAG_BITS]) begin
            rem_ff <= diff[MAG_BITS-1:0];
            quo_ff <= {quo_ff[MAG_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[MAG_BITS-1:0];
            quo_ff <= {quo_ff[MAG_BITS-2:0], 1'b0};
         end
      end
   end

   // partial remainder stays below a nonzero divisor throughout
   a_rem_below_dvs: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < dvs_ff))
      else $error("divider partial remainder reached the divisor");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && count_ff == CntW'(MAG_BITS)))
      else $error("divider did not begin iterating");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done && !start |=> !busy_ff)
      else $error("divider still busy after done");

endmodule

@@ rtl/srpg_dp.sv @@
// ----------------------------------------------------------------------------
// srpg_dp
// Move state, ramp recurrence arithmetic and result register.
// ----------------------------------------------------------------------------
module srpg_dp
   import srpg_pkg::*;
#(
   parameter int STEP_BITS  = 24,
   parameter int PULSE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  csr_wen,
   input  logic                  csr_wdata,
   input  logic                  req_type_i,
   input  logic [STEP_BITS:0]    move_steps_i,
   input  logic [STEP_BITS-1:0]  accel_steps_i,
   input  logic [STEP_BITS-1:0]  brake_steps_i,
   input  logic [PULSE_BITS-1:0] start_pulse_i,
   input  logic [PULSE_BITS-1:0] cruise_pulse_i,
   output logic                  step_taken_o,
   output logic                  direction_o,
   output logic [PULSE_BITS-1:0] interval_o,
   output logic [1:0]            phase_o,
   output logic                  last_step_o
);

   localparam int NumW = ((PULSE_BITS + 1 > STEP_BITS + 2) ? PULSE_BITS + 1
                                                            : STEP_BITS + 2) + 2;
   localparam int MagW = NumW - 1;
   localparam int RemW = STEP_BITS + 3;

   // configuration
   logic                  mode_ff;

   // latched request
   logic                  typ_ff;
   logic [STEP_BITS:0]    move_ff;
   logic [STEP_BITS-1:0]  acc_in_ff;
   logic [STEP_BITS-1:0]  brk_in_ff;
   logic [PULSE_BITS-1:0] stp_in_ff;
   logic [PULSE_BITS-1:0] crs_in_ff;

   // move state
   logic [STEP_BITS-1:0]  remaining_ff;
   logic [STEP_BITS-1:0]  done_ff;
   logic [PULSE_BITS-1:0] pulse_ff;
   logic [RemW-1:0]       carry_ff;
   logic [STEP_BITS-1:0]  accel_ff;
   logic [STEP_BITS-1:0]  brake_ff;
   logic [PULSE_BITS-1:0] cruise_ff;
   logic                  dir_ff;
   logic                  decel_ff;
   logic                  num_neg_ff;

   // result register
   logic                  out_step_ff;
   logic                  out_dir_ff;
   logic [PULSE_BITS-1:0] out_interval_ff;
   phase_type             out_phase_ff;
   logic                  out_last_ff;

   // start and step decode
   logic                  move_neg;
   logic [STEP_BITS:0]    mag_full;
   logic [STEP_BITS-1:0]  mag;
   logic [STEP_BITS-1:0]  start_accel;
   logic [STEP_BITS-1:0]  start_brake;
   logic                  has_step;
   logic [STEP_BITS-1:0]  new_rem;
   logic [STEP_BITS-1:0]  new_done;
   phase_type             step_ph;
   phase_type             start_ph;
   logic                  ramp_accel;

   // divider operands and results
   logic signed [NumW-1:0] num_s;
   logic [NumW-1:0]        num_abs;
   logic [MagW-1:0]        den_mag;
   logic [MagW-1:0]        q_mag;
   logic [MagW-1:0]        r_mag;
   logic [MagW:0]          q_s;
   logic [MagW:0]          r_s;
   logic [MagW+1:0]        np;
   logic [PULSE_BITS-1:0]  np_sat;

   function automatic phase_type phase_of(input logic [STEP_BITS-1:0] r,
                                          input logic [STEP_BITS-1:0] d,
                                          input logic [STEP_BITS-1:0] brk,
                                          input logic [STEP_BITS-1:0] acc);
      phase_type ph;
      if (r == '0) begin
         ph = PH_STOP;
      end else if (r <= brk) begin
         ph = PH_DECEL;
      end else if (d <= acc) begin
         ph = PH_ACCEL;
      end else begin
         ph = PH_CRUISE;
      end
      return ph;
   endfunction

   // step count magnitude, saturated for the most negative count
   assign move_neg    = move_ff[STEP_BITS];
   assign mag_full    = move_neg ? (~move_ff + (STEP_BITS+1)'(1)) : move_ff;
   assign mag         = mag_full[STEP_BITS] ? '1 : mag_full[STEP_BITS-1:0];
   assign start_accel = mode_ff ? acc_in_ff : '0;
   assign start_brake = mode_ff ? brk_in_ff : '0;
   assign start_ph    = phase_of(mag, '0, start_brake, start_accel);

   // bookkeeping of one step
   assign has_step   = (remaining_ff != '0);
   assign new_rem    = remaining_ff - STEP_BITS'(1);
   assign new_done   = done_ff + STEP_BITS'(1);
   assign step_ph    = phase_of(new_rem, new_done, brake_ff, accel_ff);
   assign ramp_accel = (step_ph == PH_ACCEL) && (new_done < accel_ff);

   assign sts.need_div = (typ_ff == REQ_STEP) && has_step && mode_ff &&
                         (ramp_accel || (step_ph == PH_DECEL));

   // operands: numerator 2c + rest, divisor 4n + 1 or 1 - 4r
   assign num_s   = $signed({{(NumW-PULSE_BITS-1){1'b0}}, pulse_ff, 1'b0}) +
                    $signed({{(NumW-RemW){carry_ff[RemW-1]}}, carry_ff});
   assign num_abs = num_s[NumW-1] ? (~num_s + NumW'(1)) : num_s;
   assign den_mag = decel_ff ? MagW'({new_rem, 2'b11}) : MagW'({done_ff, 2'b01});

   srpg_div #(
      .MAG_BITS (MagW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_setup),
      .dividend  (num_abs[MagW-1:0]),
      .divisor   (den_mag),
      .quotient  (q_mag),
      .remainder (r_mag),
      .done      (sts.div_done)
   );

   // truncating signed quotient and remainder, then the saturated interval
   assign q_s = (num_neg_ff ^ decel_ff) ? (~{1'b0, q_mag} + (MagW+1)'(1))
                                        : {1'b0, q_mag};
   assign r_s = num_neg_ff ? (~{1'b0, r_mag} + (MagW+1)'(1)) : {1'b0, r_mag};
   assign np  = (MagW+2)'(pulse_ff) - {q_s[MagW], q_s};

   always_comb begin
      if (np[MagW+1]) begin
         np_sat = '0;
      end else if (np[MagW:PULSE_BITS] != '0) begin
         np_sat = '1;
      end else begin
         np_sat = np[PULSE_BITS-1:0];
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_wen) begin
         mode_ff <= csr_wdata;
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         typ_ff    <= req_type_i;
         move_ff   <= move_steps_i;
         acc_in_ff <= accel_steps_i;
         brk_in_ff <= brake_steps_i;
         stp_in_ff <= start_pulse_i;
         crs_in_ff <= cruise_pulse_i;
      end
   end

   // move state
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         done_ff      <= '0;
         pulse_ff     <= '0;
         carry_ff     <= '0;
         accel_ff     <= '0;
         brake_ff     <= '0;
         cruise_ff    <= '0;
         dir_ff       <= 1'b0;
         decel_ff     <= 1'b0;
         num_neg_ff   <= 1'b0;
      end else begin
         if (cmd.commit) begin
            if (typ_ff == REQ_START) begin
               dir_ff       <= !move_neg;
               remaining_ff <= mag;
               done_ff      <= '0;
               carry_ff     <= '0;
               pulse_ff     <= stp_in_ff;
               cruise_ff    <= crs_in_ff;
               accel_ff     <= start_accel;
               brake_ff     <= start_brake;
            end else if (has_step) begin
               remaining_ff <= new_rem;
               done_ff      <= new_done;
               decel_ff     <= (step_ph == PH_DECEL);
               // end of acceleration: jump to the cruise interval
               if (mode_ff && step_ph == PH_ACCEL && !ramp_accel) begin
                  pulse_ff <= cruise_ff;
               end
            end
         end
         if (cmd.div_setup) begin
            num_neg_ff <= num_s[NumW-1];
         end
         if (cmd.div_finish) begin
            pulse_ff <= np_sat;
            carry_ff <= r_s[RemW-1:0];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (typ_ff == REQ_START) begin
            out_step_ff     <= 1'b0;
            out_dir_ff      <= !move_neg;
            out_interval_ff <= '0;
            out_phase_ff    <= start_ph;
            out_last_ff     <= 1'b0;
         end else if (has_step) begin
            out_step_ff     <= 1'b1;
            out_dir_ff      <= dir_ff;
            out_interval_ff <= (pulse_ff != '0) ? pulse_ff : PULSE_BITS'(1);
            out_phase_ff    <= step_ph;
            out_last_ff     <= (new_rem == '0);
         end else begin
            out_step_ff     <= 1'b0;
            out_dir_ff      <= dir_ff;
            out_interval_ff <= '0;
            out_phase_ff    <= PH_STOP;
            out_last_ff     <= 1'b0;
         end
      end
   end

   assign step_taken_o = out_step_ff;
   assign direction_o  = out_dir_ff;
   assign interval_o   = out_interval_ff;
   assign phase_o      = out_phase_ff;
   assign last_step_o  = out_last_ff;

   // a ramp step always leaves a move still running behind it
   a_div_has_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.div_setup |-> (remaining_ff != '0))
      else $error("ramp update started with no steps left");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && typ_ff == REQ_STEP && has_step && new_rem == '0
      |=> (out_last_ff && out_phase_ff == PH_STOP))
      else $error("final step not reported as stopping");

   a_finish_carry: assert property (@(posedge clock) disable iff (reset)
      cmd.div_finish |-> (r_mag < den_mag))
      else $error("carried remainder not below divisor");

endmodule

@@ rtl/srpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// srpg_ctrl
// Sequencer for request intake, state commit and the ramp division.
// ----------------------------------------------------------------------------
module srpg_ctrl
   import srpg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SETUP,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      slot_free;

   // result register can take a new transaction
   assign slot_free = !out_valid_ff || rsp_tready;

   assign req_tready     = (state_ff == ST_IDLE);
   assign rsp_tvalid     = out_valid_ff;
   assign cmd.capture    = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.commit     = (state_ff == ST_EXEC) && slot_free;
   assign cmd.div_setup  = (state_ff == ST_SETUP);
   assign cmd.div_finish = (state_ff == ST_FIN);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in = sts.need_div ? ST_SETUP : ST_IDLE;
            end
         end
         ST_SETUP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> out_valid_ff)
      else $error("committed result not presented");

   a_setup_needed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |-> $past(cmd.commit && sts.need_div))
      else $error("division started without a ramp step");

endmodule

@@ rtl/stepper_ramp_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Trapezoidal ramp step pulse generator with integer interval recurrence.
// ----------------------------------------------------------------------------
// Result: a transaction's result is loaded into the result register from the
//   execute state after accept, once the result register is free.
// Sequence: a start item or step without a ramp update passes idle and execute;
//   a ramp step adds setup, divide (one-bit-per-cycle divider) and finish to
//   update the interval after the result. Requests are taken only when idle.
// Reset: synchronous; clears the move state and sets linear_mode to 1.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator
   import srpg_pkg::*;
#(
   parameter int  STEP_BITS  = 24,
   parameter int  PULSE_BITS = 24,
   localparam int ReqDataW   = ((3 * STEP_BITS + 2 * PULSE_BITS + 1 + 7) / 8) * 8,
   localparam int RspDataW   = ((PULSE_BITS + 3 + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wen,
   input  logic                csr_wdata,   // linear_mode
   // request transactions
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // move_steps, accel_steps, brake_steps,
                                            // start_pulse, cruise_pulse
   input  logic                req_tuser,   // req_type
   // result transactions
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // direction, interval_us, phase
   output logic                rsp_tuser,   // step_taken
   output logic                rsp_tlast    // last_step
);

   localparam int AccLo = STEP_BITS + 1;
   localparam int BrkLo = 2 * STEP_BITS + 1;
   localparam int StpLo = 3 * STEP_BITS + 1;
   localparam int CrsLo = 3 * STEP_BITS + PULSE_BITS + 1;

   cmd_type               cmd;
   sts_type               sts;
   logic                  direction;
   logic [PULSE_BITS-1:0] interval_us;
   logic [1:0]            phase;

   srpg_dp #(
      .STEP_BITS  (STEP_BITS),
      .PULSE_BITS (PULSE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .req_type_i     (req_tuser),
      .move_steps_i   (req_tdata[STEP_BITS:0]),
      .accel_steps_i  (req_tdata[AccLo +: STEP_BITS]),
      .brake_steps_i  (req_tdata[BrkLo +: STEP_BITS]),
      .start_pulse_i  (req_tdata[StpLo +: PULSE_BITS]),
      .cruise_pulse_i (req_tdata[CrsLo +: PULSE_BITS]),
      .step_taken_o   (rsp_tuser),
      .direction_o    (direction),
      .interval_o     (interval_us),
      .phase_o        (phase),
      .last_step_o    (rsp_tlast)
   );

   srpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // result payload, first field in the low bits
   assign rsp_tdata = RspDataW'({phase, interval_us, direction});

endmodule
